FILE: hw/rtl/tbli_pkg.sv
// ----------------------------------------------------------------------------
// tbli_pkg - shared types and constants for the table interpolator
// Item layouts, command and status codes and register defaults for the
// bisection search and linear interpolation block.
// ----------------------------------------------------------------------------
package tbli_pkg;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 256;

  // Configuration port
  localparam int          CFG_AW        = 3;
  localparam logic [0:0]  REG_ENTRIES   = 1'b0;
  localparam logic [8:0]  ENTRIES_RESET = 9'd256;

  // Command codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_INSIDE = 2'd0;
  localparam logic [1:0] STATUS_EXTRAP = 2'd1;
  localparam logic [1:0] STATUS_DEGEN  = 2'd2;

  // Saturation limits in Q16.16
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Input item
  typedef struct packed {
    logic               func;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_abscissa;
    logic signed [31:0] entry_ordinate;
    logic signed [31:0] query_point;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] interp_value;
    logic [1:0]         status;
  } out_item_t;

endpackage

FILE: hw/rtl/table_bisect_linear_interp.sv
// ----------------------------------------------------------------------------
// table_bisect_linear_interp - table lookup with bisection and interpolation
// Stores (abscissa, ordinate) pairs in one synchronous memory, locates a
// query by bisection and interpolates linearly in signed Q16.16.
// ----------------------------------------------------------------------------
// A write item (func 0) gives no result and busy stays low, so writes may
// follow back to back. A query item (func 1) keeps busy high while the
// block searches and interpolates; the bisection takes floor(log2(n+1)) or
// ceil(log2(n+1)) steps over n used entries, depending on the path (8 or 9
// for 256 entries), and a degenerate segment ends early, before the
// multiply and divide. Each bisection step costs a memory read and a compare
// on the single read port, and the divide runs two quotient bits per cycle
// until all 64 are done. The result appears on out_payload with out_strobe
// high for exactly one cycle, in the cycle in which busy falls, and cannot
// be held off, so take it when it comes. The table memory is not cleared at
// reset: every entry that a query may touch must be written first.
// ----------------------------------------------------------------------------
module table_bisect_linear_interp #(
  parameter int TABLE_DEPTH = tbli_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  tbli_pkg::in_item_t          in_payload,
  // result channel
  output logic                        out_strobe,
  output tbli_pkg::out_item_t         out_payload,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbli_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 2);

  localparam logic signed [34:0] SUM_MAX = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] SUM_MIN = 35'sh7_8000_0000;
  localparam logic [64:0]        QUO_LIM = 65'h0_0000_0002_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_RDF, S_RDL, S_DIR, S_BRD, S_BCMP, S_SRD0, S_SRD1,
    S_DIFF, S_MAG, S_MUL0, S_MUL1, S_MUL2, S_DIV, S_RND, S_OUT
  } state_t;

  state_t state_r;

  // table storage: {abscissa, ordinate}
  logic [63:0]        tbl_mem_r [TABLE_DEPTH];
  logic [63:0]        rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic signed [31:0] rd_x;
  logic signed [31:0] rd_f;

  // configuration
  logic [8:0]         entries_r;
  logic               cfg_hit;
  logic [CW-1:0]      n_clamp;

  // search state
  logic               in_accept;
  logic signed [31:0] q_r;
  logic [CW-1:0]      n_r;
  logic signed [31:0] x0_r;
  logic signed [31:0] xl_r;
  logic               asc_r;
  logic [CW-1:0]      lo_p_r;
  logic [CW-1:0]      hi_p_r;
  logic [AW-1:0]      mid_r;
  logic [AW-1:0]      seg_r;
  logic               ext_r;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid_full;
  logic               bis_more;
  logic [CW-1:0]      seg_full;
  logic               seg_ext;
  logic               ge;

  // arithmetic
  logic signed [31:0] xa_r;
  logic signed [31:0] fa_r;
  logic signed [32:0] dx_r;
  logic signed [32:0] df_r;
  logic signed [32:0] dq_r;
  logic [32:0]        mag_dx_r;
  logic [32:0]        mag_df_r;
  logic [32:0]        mag_dq_r;
  logic               neg_r;
  logic [48:0]        pp_lo_r;
  logic [49:0]        pp_hi_r;
  logic [32:0]        rem_r;
  logic [63:0]        pq_r;
  logic [4:0]         div_cnt_r;
  logic [64:0]        quo_r;
  logic [96:0]        div_nxt;
  logic               rnd;
  logic signed [34:0] quo_s;
  logic signed [34:0] sum;

  // result
  logic                out_strobe_r;
  tbli_pkg::out_item_t out_payload_r;

  // Two restoring divide steps: shift in a dividend bit, subtract if it fits
  function automatic logic [96:0] div_step2(input logic [32:0] rem,
                                            input logic [63:0] pq,
                                            input logic [32:0] d);
    logic [33:0] r;
    logic [63:0] p;
    logic [32:0] rm;
    rm = rem;
    p  = pq;
    r  = '0;
    for (int i = 0; i < 2; i++) begin
      r = {rm, p[63]};
      p = {p[62:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        p[0] = 1'b1;
      end
      rm = r[32:0];
    end
    return {rm, p};
  endfunction

  assign in_accept = start && !busy;
  assign busy      = (state_r != S_IDLE);

  // Configuration register
  assign cfg_hit = (paddr[tbli_pkg::CFG_AW-1:2] == tbli_pkg::REG_ENTRIES);
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? {23'b0, entries_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= tbli_pkg::ENTRIES_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      entries_r <= pwdata[8:0];
    end
  end

  // Clamp the entry count to between two and the table depth
  always_comb begin
    if (entries_r < 9'd2) begin
      n_clamp = CW'(2);
    end else if (32'(entries_r) > 32'(TABLE_DEPTH)) begin
      n_clamp = CW'(TABLE_DEPTH);
    end else begin
      n_clamp = CW'(entries_r);
    end
  end

  // Table memory: write on a write item, one registered read a cycle
  assign tbl_we    = in_accept && (in_payload.func == tbli_pkg::FUNC_WRITE) &&
                     (32'(in_payload.entry_index) < 32'(TABLE_DEPTH));
  assign tbl_waddr = AW'(in_payload.entry_index);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem_r[tbl_waddr] <= {in_payload.entry_abscissa, in_payload.entry_ordinate};
    end
    rd_data_r <= tbl_mem_r[rd_addr];
  end

  assign rd_x = signed'(rd_data_r[63:32]);
  assign rd_f = signed'(rd_data_r[31:0]);

  // Bracket midpoint and final segment (brackets held offset by one)
  assign mid_sum  = {1'b0, lo_p_r} + {1'b0, hi_p_r};
  assign mid_full = mid_sum[CW:1] - CW'(1);
  assign bis_more = (hi_p_r - lo_p_r) > CW'(1);
  assign ge       = (q_r >= rd_x);

  always_comb begin
    if (lo_p_r == '0) begin
      seg_full = '0;
      seg_ext  = (q_r != x0_r);
    end else if (lo_p_r == n_r) begin
      seg_full = n_r - CW'(2);
      seg_ext  = (q_r != xl_r);
    end else begin
      seg_full = lo_p_r - CW'(1);
      seg_ext  = 1'b0;
    end
  end

  // Read address per state
  always_comb begin
    case (state_r)
      S_RDL:   rd_addr = AW'(n_r - CW'(1));
      S_BRD:   rd_addr = mid_full[AW-1:0];
      S_SRD0:  rd_addr = seg_r;
      S_SRD1:  rd_addr = seg_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  // Divide step and rounding
  assign div_nxt = div_step2(rem_r, pq_r, mag_dx_r);
  assign rnd     = ({rem_r, 1'b0} >= {1'b0, mag_dx_r});
  assign quo_s   = signed'({1'b0, quo_r[33:0]});
  assign sum     = neg_r ? ({{3{fa_r[31]}}, fa_r} - quo_s)
                         : ({{3{fa_r[31]}}, fa_r} + quo_s);

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_accept && (in_payload.func == tbli_pkg::FUNC_QUERY)) begin
            q_r     <= in_payload.query_point;
            n_r     <= n_clamp;
            state_r <= S_RDF;
          end
        end
        S_RDF: begin
          state_r <= S_RDL;
        end
        S_RDL: begin
          x0_r    <= rd_x;
          state_r <= S_DIR;
        end
        // Decide direction, open the bracket over the used entries
        S_DIR: begin
          xl_r    <= rd_x;
          asc_r   <= (rd_x >= x0_r);
          lo_p_r  <= '0;
          hi_p_r  <= n_r + CW'(1);
          state_r <= S_BRD;
        end
        S_BRD: begin
          if (bis_more) begin
            mid_r   <= mid_full[AW-1:0];
            state_r <= S_BCMP;
          end else begin
            seg_r   <= seg_full[AW-1:0];
            ext_r   <= seg_ext;
            state_r <= S_SRD0;
          end
        end
        // Narrow the bracket
        S_BCMP: begin
          if (ge == asc_r) begin
            lo_p_r <= CW'(mid_r) + CW'(1);
          end else begin
            hi_p_r <= CW'(mid_r) + CW'(1);
          end
          state_r <= S_BRD;
        end
        S_SRD0: begin
          state_r <= S_SRD1;
        end
        S_SRD1: begin
          xa_r    <= rd_x;
          fa_r    <= rd_f;
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          dx_r    <= 33'(rd_x) - 33'(xa_r);
          df_r    <= 33'(rd_f) - 33'(fa_r);
          dq_r    <= 33'(q_r) - 33'(xa_r);
          state_r <= S_MAG;
        end
        // Take magnitudes; a flat segment finishes here
        S_MAG: begin
          mag_dx_r <= dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
          mag_df_r <= df_r[32] ? 33'(-df_r) : 33'(df_r);
          mag_dq_r <= dq_r[32] ? 33'(-dq_r) : 33'(dq_r);
          neg_r    <= (df_r[32] != dq_r[32]) != dx_r[32];
          if (dx_r == '0) begin
            if ((df_r > 0 && dq_r > 0) || (df_r < 0 && dq_r < 0)) begin
              out_payload_r.interp_value <= tbli_pkg::Q_MAX;
            end else if ((df_r > 0 && dq_r < 0) || (df_r < 0 && dq_r > 0)) begin
              out_payload_r.interp_value <= tbli_pkg::Q_MIN;
            end else begin
              out_payload_r.interp_value <= fa_r;
            end
            out_payload_r.status <= tbli_pkg::STATUS_DEGEN;
            out_strobe_r         <= 1'b1;
            state_r              <= S_IDLE;
          end else begin
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          pp_lo_r <= mag_df_r * mag_dq_r[15:0];
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          pp_hi_r <= mag_df_r * mag_dq_r[32:16];
          state_r <= S_MUL2;
        end
        // Combine partial products, load the divider
        S_MUL2: begin
          pq_r      <= 64'(pp_lo_r) + 64'({pp_hi_r, 16'b0});
          rem_r     <= '0;
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          rem_r     <= div_nxt[96:64];
          pq_r      <= div_nxt[63:0];
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd31) begin
            state_r <= S_RND;
          end
        end
        // Round half away from zero on the magnitude
        S_RND: begin
          quo_r   <= {1'b0, pq_r} + 65'(rnd);
          state_r <= S_OUT;
        end
        // Apply sign, add the base ordinate and saturate
        S_OUT: begin
          if (quo_r > QUO_LIM) begin
            out_payload_r.interp_value <= neg_r ? tbli_pkg::Q_MIN : tbli_pkg::Q_MAX;
          end else if (sum > SUM_MAX) begin
            out_payload_r.interp_value <= tbli_pkg::Q_MAX;
          end else if (sum < SUM_MIN) begin
            out_payload_r.interp_value <= tbli_pkg::Q_MIN;
          end else begin
            out_payload_r.interp_value <= sum[31:0];
          end
          out_payload_r.status <= ext_r ? tbli_pkg::STATUS_EXTRAP
                                        : tbli_pkg::STATUS_INSIDE;
          out_strobe_r         <= 1'b1;
          state_r              <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_payload = out_payload_r;

  // A write item never causes a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_payload.func == tbli_pkg::FUNC_WRITE) |=> !out_strobe)
    else $error("result after a write item");

  // A query item always occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_payload.func == tbli_pkg::FUNC_QUERY) |=> busy)
    else $error("query item did not start work");

  // Every result follows a cycle of work
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a query in flight");

  // The search bracket stays ordered and within the used entries
  a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BRD) |-> (lo_p_r < hi_p_r && hi_p_r <= n_r + CW'(1)))
    else $error("bisection bracket out of order");

endmodule

FILE: tb/tb_table_bisect_linear_interp.sv
// ----------------------------------------------------------------------------
// tb_table_bisect_linear_interp - self-checking bench for the table interpolator
// Sets the entry count over the register port and loads tables of varying
// length and shape over the command channel: ascending, descending, with
// repeated abscissae and unordered. Queries land on entries, between them and
// beyond both ends. Every interpolated value and status is checked against an
// untimed predictor of the bisection, rounding and saturation rules.
// ----------------------------------------------------------------------------
class interp_scoreboard;
  logic signed [31:0]  abscissa_mem [tbli_pkg::TABLE_DEPTH_DEF];
  logic signed [31:0]  ordinate_mem [tbli_pkg::TABLE_DEPTH_DEF];
  logic [8:0]          entries_reg;
  tbli_pkg::out_item_t expected_results [$];
  int                  mismatches;
  int                  n_writes, n_lookups, n_extrap, n_degen;

  function new();
    entries_reg = tbli_pkg::ENTRIES_RESET;
    mismatches  = 0;
    n_writes    = 0;
    n_lookups   = 0;
    n_extrap    = 0;
    n_degen     = 0;
  endfunction

  function void set_entries(logic [8:0] v);
    entries_reg = v;
  endfunction

  // Report the first ten failures in full, count the rest
  function void flag(string msg);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endfunction

  function bit [63:0] mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function int sgn(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Locate the query by bisection, then interpolate on the chosen segment
  function tbli_pkg::out_item_t interpolate(logic signed [31:0] q);
    int                  n, s;
    longint              lo, hi, mid, seg, xa, xb, fa, fb, dx, df, dq, val;
    bit                  asc, ge, neg;
    bit [63:0]           d, p, quo, rem;
    tbli_pkg::out_item_t r;
    n = entries_reg;
    if (n < 2) n = 2;
    if (n > tbli_pkg::TABLE_DEPTH_DEF) n = tbli_pkg::TABLE_DEPTH_DEF;
    asc = abscissa_mem[n-1] >= abscissa_mem[0];
    lo  = -1;
    hi  = n;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      ge  = q >= abscissa_mem[mid];
      if (ge == asc) lo = mid;
      else hi = mid;
    end

    // clamp to the outermost segment; an exact end hit counts as inside
    r.status = tbli_pkg::STATUS_INSIDE;
    seg      = lo;
    if (lo < 0) begin
      seg = 0;
      if (q != abscissa_mem[0]) r.status = tbli_pkg::STATUS_EXTRAP;
    end else if (lo > n - 2) begin
      seg = n - 2;
      if (q != abscissa_mem[n-1]) r.status = tbli_pkg::STATUS_EXTRAP;
    end

    xa = abscissa_mem[seg];
    xb = abscissa_mem[seg+1];
    fa = ordinate_mem[seg];
    fb = ordinate_mem[seg+1];
    dx = xb - xa;
    df = fb - fa;
    dq = q - xa;

    if (dx == 0) begin
      // equal abscissae: saturate towards the sign of the slope times offset
      s        = sgn(df) * sgn(dq);
      r.status = tbli_pkg::STATUS_DEGEN;
      if (s > 0) r.interp_value = tbli_pkg::Q_MAX;
      else if (s < 0) r.interp_value = tbli_pkg::Q_MIN;
      else r.interp_value = ordinate_mem[seg];
    end else begin
      // exact magnitude product, quotient rounded half away from zero
      neg = ((df < 0) != (dq < 0)) != (dx < 0);
      d   = mag(dx);
      p   = mag(df) * mag(dq);
      quo = p / d;
      rem = p % d;
      if (rem >= d - rem) quo++;
      if (quo > 64'h2_0000_0000) begin
        val = neg ? longint'(tbli_pkg::Q_MIN) : longint'(tbli_pkg::Q_MAX);
      end else begin
        val = neg ? fa - longint'(quo) : fa + longint'(quo);
        if (val > longint'(tbli_pkg::Q_MAX)) val = longint'(tbli_pkg::Q_MAX);
        if (val < longint'(tbli_pkg::Q_MIN)) val = longint'(tbli_pkg::Q_MIN);
      end
      r.interp_value = val[31:0];
    end
    return r;
  endfunction

  // Apply a write to the shadow table, or queue the value a lookup must give
  function void note_item(tbli_pkg::in_item_t it);
    tbli_pkg::out_item_t e;
    if (it.func == tbli_pkg::FUNC_WRITE) begin
      abscissa_mem[it.entry_index] = it.entry_abscissa;
      ordinate_mem[it.entry_index] = it.entry_ordinate;
      n_writes++;
    end else begin
      e = interpolate(it.query_point);
      if (e.status == tbli_pkg::STATUS_EXTRAP) n_extrap++;
      if (e.status == tbli_pkg::STATUS_DEGEN) n_degen++;
      expected_results.push_back(e);
      n_lookups++;
    end
  endfunction

  function void check_result(tbli_pkg::out_item_t got);
    tbli_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      flag($sformatf("result %h status %0d with no lookup pending",
                     got.interp_value, got.status));
      return;
    end
    want = expected_results.pop_front();
    if (got.interp_value !== want.interp_value || got.status !== want.status)
      flag($sformatf("value %h status %0d, expected value %h status %0d",
                     got.interp_value, got.status, want.interp_value, want.status));
  endfunction
endclass

module tb_table_bisect_linear_interp;
  localparam int SETTLE_CYCLES = 70;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int CALM_TAIL     = 200;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        start      = 1'b0;
  logic                        busy;
  tbli_pkg::in_item_t          in_payload = '0;
  logic                        out_strobe;
  tbli_pkg::out_item_t         out_payload;
  logic                        psel       = 1'b0;
  logic                        penable    = 1'b0;
  logic                        pwrite     = 1'b0;
  logic [tbli_pkg::CFG_AW-1:0] paddr      = '0;
  logic [31:0]                 pwdata     = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  interp_scoreboard   sb = new();
  logic signed [31:0] cur_x [tbli_pkg::TABLE_DEPTH_DEF];
  bit                 written [tbli_pkg::TABLE_DEPTH_DEF];
  int                 gap_mode   = 1;
  int                 n_settings = 0;

  table_bisect_linear_interp dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_strobe  (out_strobe),
    .out_payload (out_payload),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Score results before noting new items taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) sb.check_result(out_payload);
      if (start && busy === 1'b0) sb.note_item(in_payload);
    end
  end

  // Now and then hold start low for a random gap; how often depends on the gap mode
  task automatic idle_gap();
    int g;
    if (gap_mode == 0) return;
    if ($urandom_range(0, (gap_mode == 1) ? 7 : 1) != 0) return;
    g = $urandom_range(1, 17);
    @(negedge clk) start <= 1'b0;
    repeat (g - 1) @(negedge clk);
  endtask

  task automatic send_item(tbli_pkg::in_item_t it);
    idle_gap();
    @(negedge clk);
    start      <= 1'b1;
    in_payload <= it;
    if (it.func == tbli_pkg::FUNC_WRITE) begin
      cur_x[it.entry_index]   = it.entry_abscissa;
      written[it.entry_index] = 1'b1;
    end
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start, let every lookup return, then allow the block to settle
  task automatic wait_drained();
    @(negedge clk) start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the entry count, then read it back
  task automatic set_entry_count(logic [8:0] v);
    logic [31:0] word;
    word      = $urandom();
    word[8:0] = v;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tbli_pkg::CFG_AW'(4 * tbli_pkg::REG_ENTRIES);
    pwdata  <= word;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_entries(v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {23'd0, v})
      sb.flag($sformatf("entry count reads %h, expected %h", prdata, {23'd0, v}));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  function automatic int eff_entries(logic [8:0] v);
    if (v < 2) return 2;
    if (v > tbli_pkg::TABLE_DEPTH_DEF) return tbli_pkg::TABLE_DEPTH_DEF;
    return v;
  endfunction

  function automatic bit prefix_written(int n);
    for (int i = 0; i < n; i++)
      if (!written[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Signed word of random magnitude
  function automatic logic signed [31:0] rand_word();
    return $signed($urandom()) >>> $urandom_range(0, 31);
  endfunction

  function automatic tbli_pkg::in_item_t write_item(logic [7:0] idx,
                                                    logic signed [31:0] x,
                                                    logic signed [31:0] f);
    tbli_pkg::in_item_t it;
    it.func           = tbli_pkg::FUNC_WRITE;
    it.entry_index    = idx;
    it.entry_abscissa = x;
    it.entry_ordinate = f;
    it.query_point    = $urandom();
    return it;
  endfunction

  function automatic tbli_pkg::in_item_t lookup_item(logic signed [31:0] q);
    tbli_pkg::in_item_t it;
    it.func           = tbli_pkg::FUNC_QUERY;
    it.entry_index    = 8'($urandom());
    it.entry_abscissa = $urandom();
    it.entry_ordinate = $urandom();
    it.query_point    = q;
    return it;
  endfunction

  function automatic logic [8:0] pick_entry_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 9'($urandom_range(256, 511));
    if (r == 1) return 9'($urandom_range(0, 1));
    if (r < 5) return 9'($urandom_range(17, 48));
    return 9'($urandom_range(2, 16));
  endfunction

  // Query on an entry, inside a segment, near an end, or anywhere
  function automatic logic signed [31:0] pick_query(int n);
    int     i;
    longint a, b, t;
    case ($urandom_range(0, 4))
      0: t = cur_x[$urandom_range(0, n - 1)];
      1, 2: begin
        i = $urandom_range(0, n - 2);
        a = cur_x[i];
        b = cur_x[i+1];
        t = a + ((b - a) * longint'($urandom_range(0, 1024))) / 1024;
      end
      3: t = longint'(cur_x[$urandom_range(0, 1) ? 0 : n - 1])
             + longint'($urandom_range(0, 64)) - 32;
      default: t = $urandom();
    endcase
    return t[31:0];
  endfunction

  // Load n entries: ascending, descending, with repeats, or unordered
  task automatic load_table(int n);
    logic signed [31:0] xs [$];
    int                 shape;
    shape = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) xs.push_back(rand_word());
    if (shape <= 1 || shape == 4) xs.sort();
    else if (shape <= 3) xs.rsort();
    if (shape == 3 || shape == 4)
      for (int i = 1; i < n; i++)
        if ($urandom_range(0, 2) == 0) xs[i] = xs[i-1];
    for (int i = 0; i < n; i++) send_item(write_item(8'(i), xs[i], rand_word()));
  endtask

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int         sent;
    int         round;
    int         n;
    int         lookups;
    logic [8:0] v;
    logic signed [31:0] x5;
    sent  = 0;
    round = 0;
    x5    = 32'sh0005_0000;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // count below two, raw units: exact ends, a rounding tie, far ends
    set_entry_count(9'd0);
    send_item(write_item(8'd0, 32'sd0, 32'sd0));
    send_item(write_item(8'd1, 32'sd2, -32'sd1));
    send_item(lookup_item(32'sd0));
    send_item(lookup_item(32'sd2));
    send_item(lookup_item(32'sd1));
    send_item(lookup_item(32'sd3));
    send_item(lookup_item(tbli_pkg::Q_MIN));
    send_item(lookup_item(tbli_pkg::Q_MAX));

    // equal abscissae: both saturation signs and the flat case
    wait_drained();
    set_entry_count(9'd1);
    send_item(write_item(8'd0, x5, 32'sd7));
    send_item(write_item(8'd1, x5, 32'sd9));
    send_item(lookup_item(x5 + 32'sd1));
    send_item(lookup_item(x5 - 32'sd1));
    send_item(lookup_item(x5));
    send_item(write_item(8'd1, x5, 32'sd7));
    send_item(lookup_item(x5 + 32'sd1));

    // descending over the full range, steep extrapolation that saturates
    wait_drained();
    set_entry_count(9'd3);
    send_item(write_item(8'd0, tbli_pkg::Q_MAX, tbli_pkg::Q_MAX));
    send_item(write_item(8'd1, 32'sd0, tbli_pkg::Q_MIN));
    send_item(write_item(8'd2, -32'sd1, tbli_pkg::Q_MAX));
    send_item(lookup_item(tbli_pkg::Q_MAX));
    send_item(lookup_item(-32'sd1));
    send_item(lookup_item(32'sd1));
    send_item(lookup_item(tbli_pkg::Q_MIN));
    send_item(lookup_item(-32'sd2));

    // random rounds: new count, usually a fresh table, then mostly lookups
    while (sent < RANDOM_ITEMS) begin
      case (round)
        0: v = 9'd256;
        1: v = 9'd2;
        2: v = 9'd511;
        default: v = pick_entry_count();
      endcase
      wait_drained();
      set_entry_count(v);
      n        = eff_entries(v);
      gap_mode = (sent >= RANDOM_ITEMS - CALM_TAIL) ? 0 : $urandom_range(0, 2);
      if (!prefix_written(n) || n < tbli_pkg::TABLE_DEPTH_DEF ||
          $urandom_range(0, 2) == 0) begin
        load_table(n);
        sent += n;
      end
      lookups = (n == tbli_pkg::TABLE_DEPTH_DEF) ? 60 : $urandom_range(10, 40);
      for (int k = 0; k < lookups; k++) begin
        if (sent >= RANDOM_ITEMS - CALM_TAIL) gap_mode = 0;
        if ($urandom_range(0, 9) == 0)
          send_item(write_item(8'($urandom()), rand_word(), rand_word()));
        else
          send_item(lookup_item(pick_query(n)));
        sent++;
      end
      round++;
    end

    // drain and settle, then judge
    @(negedge clk) start <= 1'b0;
    for (int k = 0; k < 10000 && sb.expected_results.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.flag($sformatf("%0d lookups never answered", sb.expected_results.size()));
    $display("Covered %0d table writes and %0d lookups (%0d extrapolated, %0d degenerate)",
             sb.n_writes, sb.n_lookups, sb.n_extrap, sb.n_degen);
    $display("over %0d entry-count settings; %0d mismatches seen", n_settings,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/tbli_pkg.sv
hw/rtl/table_bisect_linear_interp.sv
tb/tb_table_bisect_linear_interp.sv
